>>> rtl/itp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

  // Widths of the measurement datapath.
  localparam int TIME_W  = 32;
  localparam int ANGLE_W = 16;
  localparam int SCALE_W = 48;
  localparam int VEL_W   = 32;
  localparam int TICK_W  = 32;
  localparam int CNT_W   = $clog2(SCALE_W + 1);

  localparam logic [SCALE_W-1:0] SCALE_RESET = 48'd411774832280;
  localparam logic [VEL_W-1:0]   VEL_MAX     = '1;

  localparam logic OP_CROSS = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_VEL,
    ST_ANG,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic               start;
    logic [TIME_W-1:0]  rem_init;
    logic [SCALE_W-1:0] dividend;
    logic [TIME_W-1:0]  divisor;
    logic [CNT_W-1:0]   nbits;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [SCALE_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic               valid;
    logic [VEL_W-1:0]   velocity;
    logic [ANGLE_W-1:0] angle;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/itp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface itp_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [itp_pkg::TICK_W-1:0] time_ticks;

  modport source (output valid, output opcode, output time_ticks, input ready);
  modport sink   (input valid, input opcode, input time_ticks, output ready);
endinterface

interface itp_out_if;
  logic                        valid;
  logic                        ready;
  logic [itp_pkg::VEL_W-1:0]   velocity;
  logic [itp_pkg::ANGLE_W-1:0] angle;

  modport source (output valid, output velocity, output angle, input ready);
  modport sink   (input valid, input velocity, input angle, output ready);
endinterface

interface itp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [itp_pkg::SCALE_W-1:0] velocity_scale;

  modport source (output valid, output velocity_scale, input ready);
  modport sink   (input valid, input velocity_scale, output ready);
endinterface

`default_nettype wire

>>> rtl/itp_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The remainder can be
// preloaded so that a fraction num/den can be developed directly.
module itp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  itp_pkg::div_req_t req,
  output itp_pkg::div_rsp_t rsp
);

  logic [itp_pkg::TIME_W-1:0]  rem_r;
  logic [itp_pkg::TIME_W-1:0]  rem_nxt;
  logic [itp_pkg::TIME_W-1:0]  den_r;
  logic [itp_pkg::SCALE_W-1:0] dvd_r;
  logic [itp_pkg::SCALE_W-1:0] quo_r;
  logic [itp_pkg::CNT_W-1:0]   cnt_r;
  logic                        done_r;
  logic [itp_pkg::TIME_W:0]    trial;
  logic [itp_pkg::TIME_W:0]    diff;
  logic                        fits;

  // The remainder stays below the divisor, so the trial value fits one extra bit
  // and a clear top bit of the difference means the divisor went in.
  always_comb begin
    trial   = {rem_r, dvd_r[itp_pkg::SCALE_W-1]};
    diff    = trial - {1'b0, den_r};
    fits    = ~diff[itp_pkg::TIME_W];
    rem_nxt = fits ? diff[itp_pkg::TIME_W-1:0] : trial[itp_pkg::TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= req.nbits;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - itp_pkg::CNT_W'(1);
        if (cnt_r == itp_pkg::CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      den_r <= req.divisor;
      dvd_r <= req.dividend;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[itp_pkg::SCALE_W-2:0], 1'b0};
      quo_r <= {quo_r[itp_pkg::SCALE_W-2:0], fits};
    end
  end

  assign rsp.busy = (cnt_r != '0);
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

`default_nettype wire

>>> rtl/itp_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: holds the crossing times, forms elapsed and period, and runs
// the shared divider first for velocity and then, when the elapsed time is below the period, for the angle fraction.
module itp_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_opcode,
  input  logic [itp_pkg::TICK_W-1:0]  in_time,
  output logic                        in_ready,
  input  logic [itp_pkg::SCALE_W-1:0] scale,
  output itp_pkg::div_req_t           div_req,
  input  itp_pkg::div_rsp_t           div_rsp,
  output itp_pkg::result_t            res,
  input  logic                        res_ready
);

  itp_pkg::seq_state_t         state_r, state_nxt;
  logic [itp_pkg::TIME_W-1:0]  latest_r, latest_nxt;
  logic [itp_pkg::TIME_W-1:0]  prev_r, prev_nxt;
  logic [itp_pkg::TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic [itp_pkg::TIME_W-1:0]  period_r, period_nxt;
  logic                        use_per_r, use_per_nxt;
  logic [itp_pkg::VEL_W-1:0]   vel_r, vel_nxt;
  logic [itp_pkg::ANGLE_W-1:0] ang_r, ang_nxt;
  logic [itp_pkg::TIME_W-1:0]  now;
  logic [itp_pkg::TIME_W-1:0]  den;
  logic                        use_per_c;

  assign now      = itp_pkg::TIME_W'(in_time);
  assign in_ready = (state_r == itp_pkg::ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    latest_nxt  = latest_r;
    prev_nxt    = prev_r;
    elapsed_nxt = elapsed_r;
    period_nxt  = period_r;
    use_per_nxt = use_per_r;
    vel_nxt     = vel_r;
    ang_nxt     = ang_r;
    use_per_c   = (elapsed_r < period_r);
    den         = use_per_c ? period_r : elapsed_r;
    div_req     = '0;
    unique case (state_r)
      itp_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == itp_pkg::OP_CROSS) begin
            prev_nxt   = latest_r;
            latest_nxt = now;
          end else begin
            elapsed_nxt = now - latest_r;
            period_nxt  = latest_r - prev_r;
            state_nxt   = itp_pkg::ST_CALC;
          end
        end
      end
      itp_pkg::ST_CALC: begin
        use_per_nxt = use_per_c;
        if (den == '0) begin
          // A zero divisor can only occur on the deceleration branch.
          vel_nxt   = itp_pkg::VEL_MAX;
          ang_nxt   = '0;
          state_nxt = itp_pkg::ST_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = '0;
          div_req.dividend = scale;
          div_req.divisor  = den;
          div_req.nbits    = itp_pkg::CNT_W'(itp_pkg::SCALE_W);
          state_nxt        = itp_pkg::ST_VEL;
        end
      end
      itp_pkg::ST_VEL: begin
        if (div_rsp.done) begin
          if (div_rsp.quot[itp_pkg::SCALE_W-1:itp_pkg::VEL_W] != '0) begin
            vel_nxt = itp_pkg::VEL_MAX;
          end else begin
            vel_nxt = div_rsp.quot[itp_pkg::VEL_W-1:0];
          end
          if (use_per_r) begin
            div_req.start    = 1'b1;
            div_req.rem_init = elapsed_r;
            div_req.dividend = '0;
            div_req.divisor  = period_r;
            div_req.nbits    = itp_pkg::CNT_W'(itp_pkg::ANGLE_W);
            state_nxt        = itp_pkg::ST_ANG;
          end else begin
            ang_nxt   = '0;
            state_nxt = itp_pkg::ST_DONE;
          end
        end
      end
      itp_pkg::ST_ANG: begin
        if (div_rsp.done) begin
          ang_nxt   = div_rsp.quot[itp_pkg::ANGLE_W-1:0];
          state_nxt = itp_pkg::ST_DONE;
        end
      end
      itp_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = itp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = itp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= itp_pkg::ST_IDLE;
      latest_r <= '0;
      prev_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      latest_r <= latest_nxt;
      prev_r   <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    period_r  <= period_nxt;
    use_per_r <= use_per_nxt;
    vel_r     <= vel_nxt;
    ang_r     <= ang_nxt;
  end

  assign res.valid    = (state_r == itp_pkg::ST_DONE);
  assign res.velocity = vel_r;
  assign res.angle    = ang_r;

endmodule

`default_nettype wire

>>> rtl/index_pulse_tachometer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Index pulse tachometer.
// The input channel carries transactions of two kinds: a barrier crossing
// (opcode 0) stamps the crossing time and shifts the older one out, and a
// query (opcode 1) asks for velocity and position at its own timestamp.
// Only a query produces a transaction on the output channel, carrying the
// velocity in rad/s (unsigned Q16.16, saturated) and the position within
// the turn as an unsigned Q0.16 fraction.
// A crossing is absorbed in the cycle it is accepted and the input stays
// ready. Unless the divisor is zero, a query runs through one shared
// restoring divider that yields one quotient bit per cycle: a 48-bit
// velocity quotient and, when the position is interpolated, a 16-bit
// fraction. The input is not ready while a query is in flight, on the
// interpolating, the deceleration and the zero-divisor branch alike, so a
// new query is taken only after the last result has left the sequencer.
// The cfg channel is always ready and writes the velocity scale; write it
// only while no query is in flight.
// Reset clears both crossing times to zero, loads the default scale and
// empties the output register. If the receiver stalls, the result waits in
// the output register and the input takes crossings and one more query;
// that query then holds the input off until the output register frees up.
module index_pulse_tachometer_top (
  input  logic        clk,
  input  logic        rst_n,
  itp_in_if.sink      in_ch,
  itp_out_if.source   out_ch,
  itp_cfg_if.sink     cfg_ch
);

  logic [itp_pkg::SCALE_W-1:0] scale_r;
  logic                        out_valid_r;
  logic [itp_pkg::VEL_W-1:0]   out_vel_r;
  logic [itp_pkg::ANGLE_W-1:0] out_ang_r;
  logic                        seq_ready;
  logic                        res_ready;
  itp_pkg::div_req_t           div_req;
  itp_pkg::div_rsp_t           div_rsp;
  itp_pkg::result_t            res;

  // The scale register accepts a write on every cycle.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= itp_pkg::SCALE_RESET;
    end else if (cfg_ch.valid) begin
      scale_r <= cfg_ch.velocity_scale;
    end
  end

  assign in_ch.ready = seq_ready;

  itp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_time   (in_ch.time_ticks),
    .in_ready  (seq_ready),
    .scale     (scale_r),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .res       (res),
    .res_ready (res_ready)
  );

  itp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Output register: a finished result is parked here so the sequencer can
  // return to idle while the receiver holds off.
  assign res_ready = ~out_valid_r | out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_vel_r <= res.velocity;
      out_ang_r <= res.angle;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.velocity = out_vel_r;
  assign out_ch.angle    = out_ang_r;

  // The sequencer must never restart the divider in the middle of a division.
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A query occupies the block, so the input drops ready right after it.
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.opcode == itp_pkg::OP_QUERY))
      |=> !in_ch.ready)
    else $error("input still ready after a query transaction");

  // A crossing is absorbed at once and leaves the input ready.
  a_cross_absorbed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.opcode == itp_pkg::OP_CROSS))
      |=> in_ch.ready)
    else $error("input not ready after a crossing transaction");

  // A new output transaction only appears after the sequencer finished one.
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res.valid))
    else $error("output valid without a finished result");

endmodule

`default_nettype wire
